@@ rtl/sbc_pkg.sv @@
package sbc_pkg;

    localparam int WORD_W      = 32;
    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS      = 64;
    localparam int HASH_WORDS  = 8;
    localparam int CNT_W       = $clog2(BLOCK_WORDS);
    localparam int ROUND_W     = $clog2(ROUNDS);
    localparam int IDX_W       = $clog2(HASH_WORDS);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROUND,
        ST_FINAL,
        ST_EMIT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic               load_word;
        logic               restart;
        logic               init_rounds;
        logic               do_round;
        logic               add_hash;
        logic [ROUND_W-1:0] round_idx;
        logic [IDX_W-1:0]   out_idx;
    } t_sbc_cmd;

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] ssig0(input logic [WORD_W-1:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [WORD_W-1:0] ssig1(input logic [WORD_W-1:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [WORD_W-1:0] bsig0(input logic [WORD_W-1:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [WORD_W-1:0] bsig1(input logic [WORD_W-1:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [WORD_W-1:0] ch_f(input logic [WORD_W-1:0] e,
                                               input logic [WORD_W-1:0] f,
                                               input logic [WORD_W-1:0] g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic logic [WORD_W-1:0] maj_f(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b,
                                                input logic [WORD_W-1:0] c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

    function automatic logic [WORD_W-1:0] init_h(input logic [IDX_W-1:0] i);
        logic [WORD_W-1:0] v;
        unique case (i)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            3'd7: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] t);
        logic [WORD_W-1:0] v;
        unique case (t)
            6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
            6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
            6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
            6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
            6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
            6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
            6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
            6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
            6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
            6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
            6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
            6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
            6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
            6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
            6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
            6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
            6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
            6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
            6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
            6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
            6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
            6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
            6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
            6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
            6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
            6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
            6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
            6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
            6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
            6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
            6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
            6'd62: v = 32'hbef9a3f7;  6'd63: v = 32'hc67178f2;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/sha256_block_compress_top.sv @@
// sha-256 block compressor: one 32-bit word request per cycle while loading a block
// after the 16th word of a block: 64 rounds, one hash add, then the first digest word is shown;
//   when the end flag falls in mid block the partial block is dropped and the digest goes out
// per 512-bit block: 16 loads, 64 rounds and 1 add in turn, no new word taken before the add,
//   set by the single round unit doing one round per cycle; digest takes 8 output requests
// reset: synchronous active low; hash reloads the initial values, controller back to load
module sha256_block_compress_top
    import sbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] message_word
    input  logic [0:0]  s_axis_tuser,   // [0] new_message
    input  logic        s_axis_tlast,   // end_of_message
    // digest stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] digest_index, rest zero
    output logic        m_axis_tlast    // digest_last
);

    // command bundle from controller to datapath
    t_sbc_cmd          cmd;
    logic [WORD_W-1:0] digest_word;

    // state machine: load / rounds / hash add / digest out
    sbc_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (s_axis_tvalid),
        .i_new_message    (s_axis_tuser[0]),
        .i_end_of_message (s_axis_tlast),
        .o_s_tready       (s_axis_tready),
        .o_m_tvalid       (m_axis_tvalid),
        .i_m_tready       (m_axis_tready),
        .o_m_tlast        (m_axis_tlast),
        .o_cmd            (cmd)
    );

    // hash registers, working variables, schedule window and the round unit
    sbc_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_message_word (s_axis_tdata),
        .o_digest_word  (digest_word)
    );

    // pack digest word and its index, pad to whole bytes
    assign m_axis_tdata = {5'b0, cmd.out_idx, digest_word};

endmodule

@@ rtl/sbc_ctrl.sv @@
module sbc_ctrl
    import sbc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    input  logic     i_new_message,
    input  logic     i_end_of_message,
    output logic     o_s_tready,
    output logic     o_m_tvalid,
    input  logic     i_m_tready,
    output logic     o_m_tlast,
    output t_sbc_cmd o_cmd
);

    localparam logic [CNT_W-1:0]   LAST_WORD  = CNT_W'(BLOCK_WORDS - 1);
    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);
    localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(HASH_WORDS - 1);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_word_cnt, n_word_cnt;
    logic [ROUND_W-1:0] r_round_cnt, n_round_cnt;
    logic [IDX_W-1:0]   r_out_idx, n_out_idx;
    logic               r_finish, n_finish;
    logic [CNT_W-1:0]   eff_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_word_cnt  <= '0;
            r_round_cnt <= '0;
            r_out_idx   <= '0;
            r_finish    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_word_cnt  <= n_word_cnt;
            r_round_cnt <= n_round_cnt;
            r_out_idx   <= n_out_idx;
            r_finish    <= n_finish;
        end
    end

    assign eff_cnt = i_new_message ? '0 : r_word_cnt;

    always_comb begin
        n_state     = r_state;
        n_word_cnt  = r_word_cnt;
        n_round_cnt = r_round_cnt;
        n_out_idx   = r_out_idx;
        n_finish    = r_finish;
        o_s_tready  = 1'b0;
        o_m_tvalid  = 1'b0;
        o_m_tlast   = 1'b0;
        o_cmd       = '0;
        o_cmd.round_idx = r_round_cnt;
        o_cmd.out_idx   = r_out_idx;
        unique case (r_state)
            ST_LOAD: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_word = 1'b1;
                    o_cmd.restart   = i_new_message;
                    n_word_cnt      = eff_cnt + 1'b1;
                    if (eff_cnt == LAST_WORD) begin
                        o_cmd.init_rounds = 1'b1;
                        n_finish          = i_end_of_message;
                        n_state           = ST_ROUND;
                    end else if (i_end_of_message) begin
                        // partial block dropped, digest is the hash as it stands
                        n_word_cnt = '0;
                        n_out_idx  = '0;
                        n_state    = ST_EMIT;
                    end
                end
            end
            ST_ROUND: begin
                o_cmd.do_round = 1'b1;
                n_round_cnt    = r_round_cnt + 1'b1;
                if (r_round_cnt == LAST_ROUND) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                o_cmd.add_hash = 1'b1;
                n_out_idx      = '0;
                n_state        = r_finish ? ST_EMIT : ST_LOAD;
            end
            ST_EMIT: begin
                o_m_tvalid = 1'b1;
                o_m_tlast  = (r_out_idx == LAST_IDX);
                if (i_m_tready) begin
                    n_out_idx = r_out_idx + 1'b1;
                    if (r_out_idx == LAST_IDX) begin
                        n_state = ST_LOAD;
                    end
                end
            end
        endcase
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input and output sides open at once");

    a_round_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_ROUND) |-> (r_round_cnt == '0))
        else $error("round counter not at zero outside rounds");

    a_digest_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> o_s_tready)
        else $error("input not reopened after last digest word");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(r_out_idx)))
        else $error("digest index moved under stall");

    a_block_to_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.init_rounds |=> (r_state == ST_ROUND && r_round_cnt == '0))
        else $error("full block did not start rounds");

endmodule

@@ rtl/sbc_datapath.sv @@
module sbc_datapath
    import sbc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_sbc_cmd          i_cmd,
    input  logic [WORD_W-1:0] i_message_word,
    output logic [WORD_W-1:0] o_digest_word
);

    logic [WORD_W-1:0] r_hash  [HASH_WORDS];
    logic [WORD_W-1:0] r_var   [HASH_WORDS];   // a..h
    logic [WORD_W-1:0] r_sched [BLOCK_WORDS];  // sliding window, entry 0 is W[t]

    logic [WORD_W-1:0] n_sched_in;
    logic [WORD_W-1:0] w_t1, w_t2;

    // next schedule word from the fixed window taps
    assign n_sched_in = ssig1(r_sched[14]) + r_sched[9] + ssig0(r_sched[1]) + r_sched[0];

    assign w_t1 = r_var[7] + bsig1(r_var[4]) + ch_f(r_var[4], r_var[5], r_var[6])
                + round_k(i_cmd.round_idx) + r_sched[0];
    assign w_t2 = bsig0(r_var[0]) + maj_f(r_var[0], r_var[1], r_var[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                r_hash[i] <= init_h(IDX_W'(i));
            end
        end else if (i_cmd.restart) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                r_hash[i] <= init_h(IDX_W'(i));
            end
        end else if (i_cmd.add_hash) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                r_hash[i] <= r_hash[i] + r_var[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_word || i_cmd.do_round) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                r_sched[i] <= r_sched[i+1];
            end
            r_sched[BLOCK_WORDS-1] <= i_cmd.load_word ? i_message_word : n_sched_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                r_var[i] <= '0;
            end
        end else if (i_cmd.init_rounds) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                r_var[i] <= r_hash[i];
            end
        end else if (i_cmd.do_round) begin
            r_var[7] <= r_var[6];
            r_var[6] <= r_var[5];
            r_var[5] <= r_var[4];
            r_var[4] <= r_var[3] + w_t1;
            r_var[3] <= r_var[2];
            r_var[2] <= r_var[1];
            r_var[1] <= r_var[0];
            r_var[0] <= w_t1 + w_t2;
        end
    end

    assign o_digest_word = r_hash[i_cmd.out_idx];

endmodule
